// File: rtl/vgmcse_pkg.sv
`default_nettype none

package vgmcse_pkg;

   // Request operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Wait values with a one-byte command of their own
   localparam logic [15:0] WAIT_NTSC      = 16'd735;
   localparam logic [15:0] WAIT_PAL       = 16'd882;
   localparam logic [15:0] WAIT_SHORT_MAX = 16'd16;

   // Command bytes
   localparam logic [7:0] CMD_WAIT       = 8'h61;
   localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
   localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
   localparam logic [7:0] CMD_WAIT_SHORT = 8'h70;
   localparam logic [7:0] CMD_WRITE      = 8'hb4;
   localparam logic [7:0] CMD_END        = 8'h66;

   // Byte counts of the command pieces
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_SHORT = 3'd1;
   localparam logic [2:0] LEN_LONG  = 3'd3;

   // Most bytes one request can expand to
   localparam int JOB_BYTES = 6;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // One encoded request: its bytes, the index of its final byte and totals
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                last_idx;
      logic [31:0]               sample_total;
      logic [31:0]               loop_byte_offset;
      logic [31:0]               loop_sample_total;
   } job_type;

   // Queue write port
   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // Queue read port
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

`default_nettype wire

// File: rtl/vgmcse_req_if.sv
`default_nettype none

interface vgmcse_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] wait_count;
   logic [15:0] reg_word;

   modport source (output valid, output operation, output wait_count, output reg_word,
                   input ready);
   modport sink (input valid, input operation, input wait_count, input reg_word,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/vgmcse_rsp_if.sv
`default_nettype none

interface vgmcse_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last_byte;
   logic [31:0] sample_total;
   logic [31:0] loop_byte_offset;
   logic [31:0] loop_sample_total;

   modport source (output valid, output out_byte, output last_byte, output sample_total,
                   output loop_byte_offset, output loop_sample_total, input ready);
   modport sink (input valid, input out_byte, input last_byte, input sample_total,
                 input loop_byte_offset, input loop_sample_total, output ready);
endinterface

`default_nettype wire

// File: rtl/vgmcse_csr_if.sv
`default_nettype none

interface vgmcse_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] loop_start_record;

   modport source (output valid, output loop_start_record, input ready);
   modport sink (input valid, input loop_start_record, output ready);
endinterface

`default_nettype wire

// File: rtl/vgmcse_front.sv
`default_nettype none

module vgmcse_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   vgmcse_req_if.sink               req,
   vgmcse_csr_if.sink               csr,
   output vgmcse_pkg::push_type     push,
   input  wire logic                queue_full
);
   import vgmcse_pkg::*;

   localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

   logic [31:0]            loop_start_ff;
   logic [COUNT_WIDTH-1:0] record_index_ff, record_index_in;
   logic [COUNT_WIDTH-1:0] byte_offset_ff, byte_offset_in;
   logic [COUNT_WIDTH-1:0] samples_sum_ff, samples_sum_in;
   logic [COUNT_WIDTH-1:0] loop_mark_ff, loop_mark_in;
   logic [COUNT_WIDTH-1:0] loop_span_ff, loop_span_in;

   logic                   accept;
   logic                   is_finish;
   logic [2:0]             wait_len;
   logic [2:0]             write_len;
   logic [7:0]             wait_cmd;
   logic                   at_loop_point;
   logic                   has_loop;
   logic [EXT_W-1:0]       samples_ext;
   logic [EXT_W-1:0]       mark_ext;
   logic [EXT_W-1:0]       loop_span_ext;
   logic [7:0]             reg_addr;
   logic [7:0]             reg_data;
   job_type                job;

   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign is_finish = (req.operation == OP_FINISH);
   assign reg_addr  = req.reg_word[15:8];
   assign reg_data  = req.reg_word[7:0];

   // Classify the wait
   always_comb begin
      wait_cmd = CMD_WAIT;
      wait_len = LEN_LONG;
      if (req.wait_count == '0) begin
         wait_len = LEN_NONE;
      end else if (req.wait_count == WAIT_NTSC) begin
         wait_cmd = CMD_WAIT_NTSC;
         wait_len = LEN_SHORT;
      end else if (req.wait_count == WAIT_PAL) begin
         wait_cmd = CMD_WAIT_PAL;
         wait_len = LEN_SHORT;
      end else if (req.wait_count <= WAIT_SHORT_MAX) begin
         wait_cmd = CMD_WAIT_SHORT + 8'(req.wait_count - 16'd1);
         wait_len = LEN_SHORT;
      end
   end

   assign write_len = (req.reg_word != '0) ? LEN_LONG : LEN_NONE;

   // Loop point sits after the wait and before the write
   assign at_loop_point = (record_index_ff != '0) &&
                          (EXT_W'(record_index_ff) == EXT_W'(loop_start_ff));

   // Report counters as their low 32 bits
   assign has_loop      = (loop_mark_ff != '0);
   assign samples_ext   = EXT_W'(samples_sum_ff);
   assign mark_ext      = EXT_W'(loop_mark_ff);
   assign loop_span_ext = EXT_W'(loop_span_ff);

   // Lay out the bytes of this request
   always_comb begin
      job                   = '0;
      if (is_finish) begin
         job.bytes[0]          = CMD_END;
         job.last_idx          = 3'd0;
         job.sample_total      = samples_ext[31:0];
         job.loop_byte_offset  = has_loop ? mark_ext[31:0] : 32'd0;
         job.loop_sample_total = has_loop ? loop_span_ext[31:0] : 32'd0;
      end else begin
         job.last_idx = wait_len + write_len - 3'd1;
         unique case (wait_len)
            LEN_LONG: begin
               job.bytes[0] = wait_cmd;
               job.bytes[1] = req.wait_count[7:0];
               job.bytes[2] = req.wait_count[15:8];
               job.bytes[3] = CMD_WRITE;
               job.bytes[4] = reg_addr;
               job.bytes[5] = reg_data;
            end
            LEN_SHORT: begin
               job.bytes[0] = wait_cmd;
               job.bytes[1] = CMD_WRITE;
               job.bytes[2] = reg_addr;
               job.bytes[3] = reg_data;
            end
            default: begin
               job.bytes[0] = CMD_WRITE;
               job.bytes[1] = reg_addr;
               job.bytes[2] = reg_data;
            end
         endcase
      end
   end

   // Queue only requests that emit bytes
   assign push.valid = accept && (is_finish || (wait_len != LEN_NONE) ||
                                  (write_len != LEN_NONE));
   assign push.job   = job;

   // Advance the stream counters
   always_comb begin
      record_index_in = record_index_ff;
      byte_offset_in  = byte_offset_ff;
      samples_sum_in  = samples_sum_ff;
      loop_mark_in    = loop_mark_ff;
      loop_span_in    = loop_span_ff;
      if (accept) begin
         if (is_finish) begin
            record_index_in = '0;
            byte_offset_in  = '0;
            samples_sum_in  = '0;
            loop_mark_in    = '0;
            loop_span_in    = '0;
         end else begin
            record_index_in = record_index_ff + COUNT_WIDTH'(1);
            byte_offset_in  = byte_offset_ff + COUNT_WIDTH'(wait_len + write_len);
            samples_sum_in  = samples_sum_ff + COUNT_WIDTH'(req.wait_count);
            if (at_loop_point) begin
               loop_mark_in = byte_offset_ff + COUNT_WIDTH'(wait_len);
               loop_span_in = '0;
            end else begin
               loop_span_in = loop_span_ff + COUNT_WIDTH'(req.wait_count);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_start_ff   <= '0;
         record_index_ff <= '0;
         byte_offset_ff  <= '0;
         samples_sum_ff  <= '0;
         loop_mark_ff    <= '0;
         loop_span_ff    <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            loop_start_ff <= csr.loop_start_record;
         end
         record_index_ff <= record_index_in;
         byte_offset_ff  <= byte_offset_in;
         samples_sum_ff  <= samples_sum_in;
         loop_mark_ff    <= loop_mark_in;
         loop_span_ff    <= loop_span_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/vgmcse_queue.sv
`default_nettype none

module vgmcse_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  vgmcse_pkg::push_type  push,
   output logic                  full,
   output vgmcse_pkg::head_type  head,
   input  wire logic             pop
);
   import vgmcse_pkg::*;

   job_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QUEUE_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("request pushed into full command queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("command queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("command queue count out of range");

endmodule

`default_nettype wire

// File: rtl/vgmcse_back.sv
`default_nettype none

module vgmcse_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  vgmcse_pkg::head_type  head,
   output logic                  pop,
   vgmcse_rsp_if.source          rsp
);
   import vgmcse_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [31:0] sample_total_ff;
   logic [31:0] loop_offset_ff;
   logic [31:0] loop_total_ff;
   logic        load;
   logic        is_last;

   // Load a byte whenever the output register is free or being drained
   assign load    = head.valid && (!valid_ff || rsp.ready);
   assign is_last = (idx_ff == head.job.last_idx);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the output payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff         <= head.job.bytes[idx_ff];
         last_ff         <= is_last;
         sample_total_ff <= head.job.sample_total;
         loop_offset_ff  <= head.job.loop_byte_offset;
         loop_total_ff   <= head.job.loop_sample_total;
      end
   end

   assign rsp.valid             = valid_ff;
   assign rsp.out_byte          = byte_ff;
   assign rsp.last_byte         = last_ff;
   assign rsp.sample_total      = sample_total_ff;
   assign rsp.loop_byte_offset  = loop_offset_ff;
   assign rsp.loop_sample_total = loop_total_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> idx_ff <= head.job.last_idx)
      else $error("byte index past end of command");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> idx_ff == 3'd0)
      else $error("byte index not cleared with empty queue");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("command retired without last byte");

endmodule

`default_nettype wire

// File: rtl/vgm_command_stream_encoder_core.sv
`default_nettype none

// Command stream encoder. Each record request (a wait in samples plus a register
// write word) becomes 0 to 6 command bytes on the response channel, one byte per
// response, with last_byte set on the final byte of each request; a finish
// request yields a single 0x66 byte carrying the sample total and loop totals and
// then restarts the stream counters. The front end updates all counters in the
// cycle a request is accepted and pushes the encoded bytes into a 4-entry
// command queue, so requests are taken one per cycle while the queue has room.
// The back end drains one byte per cycle into the output register while the
// response is taken, so a record emits up to 6 bytes, a finish one byte, and a
// record with no wait and no write none; sustained rate is set by the output byte
// count. loop_start_record is written through the csr channel, which is always
// ready; the user must write it only while no request is in flight (unenforced).
module vgm_command_stream_encoder_core #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   vgmcse_req_if.sink   req_chan,
   vgmcse_rsp_if.source rsp_chan,
   vgmcse_csr_if.sink   csr_chan
);
   import vgmcse_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   vgmcse_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push       (push),
      .queue_full (queue_full)
   );

   vgmcse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   vgmcse_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
